/* rtl/core/bbd_pkg.sv */
// shared types, constants and helpers for the bilinear bayer demosaic block
package bbd_pkg;

  // default frame store limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // configuration register layout
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_MIN   = 11'd2;

  // input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // pixel and coordinate widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int SUM_W   = 10;
  localparam int CNT_W   = 3;

  // floor(s / 3) as (s * Recip3) >> Recip3Shift, exact for s below 1024
  localparam int RECIP3_W     = 11;
  localparam int Recip3Shift  = 11;
  localparam logic [RECIP3_W-1:0] Recip3 = 11'd683;

  // filter colors
  typedef enum logic [1:0] {
    COL_G = 2'd0,
    COL_R = 2'd1,
    COL_B = 2'd2
  } colour_t;

  // color of a site from row and column parity: G B on even rows, R G on odd rows
  function automatic colour_t site_colour(input logic row_odd, input logic col_odd);
    colour_t c;
    if (!row_odd) begin
      c = col_odd ? COL_B : COL_G;
    end else begin
      c = col_odd ? COL_G : COL_R;
    end
    return c;
  endfunction

  // floor mean of a neighbor sum over its count of one to four
  function automatic logic [PIX_W-1:0] mean_of(input logic [SUM_W-1:0] s,
                                               input logic [CNT_W-1:0] n);
    logic [SUM_W+RECIP3_W-1:0] prod;
    logic [PIX_W-1:0]          v;
    prod = (SUM_W+RECIP3_W)'(s) * (SUM_W+RECIP3_W)'(Recip3);
    case (n)
      3'd1:    v = s[PIX_W-1:0];
      3'd2:    v = s[PIX_W:1];
      3'd3:    v = PIX_W'(prod >> Recip3Shift);
      3'd4:    v = s[PIX_W+1:2];
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/bayer_bilinear_demosaic.sv */
// bilinear bayer demosaic over a 3x3 window with a two-row line store
//
// Raw samples enter in raster order on the input channel (in_valid, in_stall,
// command, raw_value); the pattern is G B on even rows and R G on odd rows.
// Each site leaves on the output channel (out_valid, out_stall) as red, green,
// blue plus its row, column and a frame_last flag on the bottom right pixel.
// Output lags input by frame_width + 1 beats; after the frame's last pixel the
// source sends frame_width + 1 drain beats to flush the tail, and the frame
// restarts by itself right after the frame_last beat.
// Processing: an item that yields a pixel passes accept, line store read,
// neighbor sums, then mean and output load, where out_valid rises; one that
// yields none (first row, start of the second row) ends after the line store
// read; a drain beat sent while pixels are still expected is swallowed at
// accept. in_stall stays high while an item is in work.
// A finished result sits in the output register; while out_stall holds it the
// block still takes the next item and parks it just before the output load.
// Reset (rst, synchronous) restores 640 x 480, clears position and window;
// line store contents are left as they are and only feed off-frame taps.
// Any configuration write also restarts the frame.
module bayer_bilinear_demosaic #(
  parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbd_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write_en,
  input  logic [bbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic [bbd_pkg::PIX_W-1:0]        raw_value,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bbd_pkg::PIX_W-1:0]        red,
  output logic [bbd_pkg::PIX_W-1:0]        green,
  output logic [bbd_pkg::PIX_W-1:0]        blue,
  output logic [bbd_pkg::COORD_W-1:0]      pixel_row,
  output logic [bbd_pkg::COORD_W-1:0]      pixel_col,
  output logic                             frame_last
);
  import bbd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CALC = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CFG_DATA_W-1:0] frame_width, frame_height;
  logic [WW-1:0]         w_eff;
  logic [HW-1:0]         h_eff;

  logic [RW-1:0] in_row;
  logic [WW-1:0] in_col;
  logic [WW-1:0] col_eff;

  // item latched at accept
  logic [PIX_W-1:0] item_raw;
  logic             item_pixel;

  // line store: low byte previous row, high byte the row before
  logic [2*PIX_W-1:0] line_store [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;

  logic [PIX_W-1:0] win      [3][3];
  logic [PIX_W-1:0] emit_win [3][3];

  logic          emit_flag;
  logic [RW-1:0] emit_row;
  logic [WW-1:0] emit_col;
  logic          emit_last;

  logic [SUM_W-1:0] sum_acc [3];
  logic [CNT_W-1:0] cnt_acc [3];
  logic [SUM_W-1:0] sum_q   [3];
  logic [CNT_W-1:0] cnt_q   [3];
  colour_t          nc;
  colour_t          own_q;
  logic [PIX_W-1:0] centre_q;
  logic [2:0]       row_ok, col_ok;

  logic in_accept, skip_item, col_zero, is_last, load_out;
  logic [RW-1:0] h_ext;

  // clamp frame size registers into the supported range
  always_comb begin
    if (frame_width < FRAME_SIZE_MIN) begin
      w_eff = WW'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width);
    end
    if (frame_height < FRAME_SIZE_MIN) begin
      h_eff = HW'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height);
    end
  end

  assign h_ext     = RW'(h_eff);
  assign col_eff   = (in_col >= w_eff) ? '0 : in_col;
  assign col_zero  = (col_eff == '0);
  assign is_last   = (in_row == h_ext + RW'(1));
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  // a drain beat while pixels are still due is dropped
  assign skip_item = (in_row < h_ext) && (command == CMD_DRAIN);
  assign load_out  = (state == S_OUT) && (!out_valid || !out_stall);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_accept && !skip_item) state_next = S_READ;
      S_READ: begin
        if ((col_zero && in_row >= RW'(2)) || (!col_zero && in_row >= RW'(1))) begin
          state_next = S_CALC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CALC:  state_next = S_OUT;
      S_OUT:   if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // line store: read at accept, written back in the next cycle; the next read
  // comes only after the write, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (in_accept && !skip_item) begin
      rd_data <= line_store[col_eff[AW-1:0]];
    end
    if (state == S_READ && item_pixel) begin
      line_store[col_eff[AW-1:0]] <= {rd_data[PIX_W-1:0], item_raw};
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_accept && !skip_item) begin
      item_pixel <= (in_row < h_ext);
      item_raw   <= (in_row < h_ext) ? raw_value : '0;
    end
  end

  // configuration, position and window
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      in_row       <= '0;
      in_col       <= '0;
      win          <= '{default: '0};
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
      in_row <= '0;
      in_col <= '0;
      win    <= '{default: '0};
    end else if (state == S_READ) begin
      // shift in the new column; a row start first pushes an empty column
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= col_zero ? win[k][2] : win[k][1];
        win[k][1] <= col_zero ? '0        : win[k][2];
      end
      win[0][2] <= rd_data[2*PIX_W-1:PIX_W];
      win[1][2] <= rd_data[PIX_W-1:0];
      win[2][2] <= item_raw;
      // advance input position
      if (col_zero && is_last) begin
        in_row <= '0;
        in_col <= '0;
      end else if (col_eff + WW'(1) >= w_eff) begin
        in_col <= '0;
        in_row <= in_row + RW'(1);
      end else begin
        in_col <= col_eff + WW'(1);
      end
    end
  end

  // window and coordinates of the site to emit
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      for (int k = 0; k < 3; k++) begin
        emit_win[k][0] <= col_zero ? win[k][1] : win[k][1];
        emit_win[k][1] <= win[k][2];
      end
      emit_win[0][2] <= col_zero ? '0 : rd_data[2*PIX_W-1:PIX_W];
      emit_win[1][2] <= col_zero ? '0 : rd_data[PIX_W-1:0];
      emit_win[2][2] <= col_zero ? '0 : item_raw;
      emit_flag      <= col_zero ? (in_row >= RW'(2)) : (in_row >= RW'(1));
      emit_row       <= col_zero ? in_row - RW'(2) : in_row - RW'(1);
      emit_col       <= col_zero ? w_eff - WW'(1) : col_eff - WW'(1);
      emit_last      <= col_zero && is_last;
    end
  end

  // which neighbor rows and columns lie inside the frame
  always_comb begin
    row_ok[0] = (emit_row != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = ((emit_row + RW'(1)) < h_ext);
    col_ok[0] = (emit_col != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = ((emit_col + WW'(1)) < w_eff);
  end

  // per-color neighbor sums and counts
  always_comb begin
    nc = COL_G;
    for (int c = 0; c < 3; c++) begin
      sum_acc[c] = '0;
      cnt_acc[c] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(k == 1 && j == 1) && row_ok[k] && col_ok[j]) begin
          nc = site_colour(emit_row[0] ^ 1'(k != 1), emit_col[0] ^ 1'(j != 1));
          sum_acc[nc] = sum_acc[nc] + SUM_W'(emit_win[k][j]);
          cnt_acc[nc] = cnt_acc[nc] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      sum_q    <= sum_acc;
      cnt_q    <= cnt_acc;
      own_q    <= site_colour(emit_row[0], emit_col[0]);
      centre_q <= emit_win[1][1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= emit_flag;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red        <= (own_q == COL_R) ? centre_q : mean_of(sum_q[COL_R], cnt_q[COL_R]);
      green      <= (own_q == COL_G) ? centre_q : mean_of(sum_q[COL_G], cnt_q[COL_G]);
      blue       <= (own_q == COL_B) ? centre_q : mean_of(sum_q[COL_B], cnt_q[COL_B]);
      pixel_row  <= COORD_W'(emit_row);
      pixel_col  <= COORD_W'(emit_col);
      frame_last <= emit_last;
    end
  end

endmodule

/* rtl/core/bbd_checker.sv */
// port-level checks for the bilinear bayer demosaic block, with its bind
module bbd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            command,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [bbd_pkg::PIX_W-1:0]       red,
  input logic [bbd_pkg::PIX_W-1:0]       green,
  input logic [bbd_pkg::PIX_W-1:0]       blue,
  input logic [bbd_pkg::COORD_W-1:0]     pixel_row,
  input logic [bbd_pkg::COORD_W-1:0]     pixel_col,
  input logic                            frame_last
);
  import bbd_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({red, green, blue, pixel_row, pixel_col, frame_last}))
    else $error("output payload changed while stalled");

  // a pixel beat always keeps the block busy for the following cycle
  a_busy_after_pixel: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_PIXEL |=> in_stall)
    else $error("input taken again right after a pixel beat");

  // a fresh output beat only appears while an item is in work
  a_fresh_out_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!$past(out_valid) || !$past(out_stall)) |-> $past(in_stall))
    else $error("output beat appeared with no item in work");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (.*);
